FILE: sv/slrp_pkg.sv
// ----------------------------------------------------------------------------
// Sensor line response parser package
// Shared types, byte codes, result kinds and prefix tables.
// ----------------------------------------------------------------------------
package slrp_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [1:0]  kind_t;
    typedef logic [15:0] value_t;

    localparam int LINE_BUFFER_DEPTH_DEF = 32;

    localparam byte_t BYTE_CR    = 8'h0D;
    localparam byte_t BYTE_LF    = 8'h0A;
    localparam byte_t BYTE_DOT   = 8'h2E;
    localparam byte_t BYTE_EQUAL = 8'h3D;
    localparam byte_t DIGIT_ZERO = 8'h30;

    localparam kind_t KIND_VERSION = 2'd0;
    localparam kind_t KIND_VOLTAGE = 2'd1;
    localparam kind_t KIND_OK      = 2'd2;
    localparam kind_t KIND_PH      = 2'd3;

    localparam logic [3:0] LEN_VERSION = 4'd9;
    localparam logic [3:0] LEN_VOLTAGE = 4'd3;
    localparam logic [3:0] LEN_OK      = 4'd2;
    localparam logic [3:0] LEN_PH      = 4'd4;

    function automatic byte_t char_version(input logic [3:0] idx);
        case (idx)
            4'd0:    return 8'h2B;
            4'd1:    return 8'h56;
            4'd2:    return 8'h45;
            4'd3:    return 8'h52;
            4'd4:    return 8'h53;
            4'd5:    return 8'h49;
            4'd6:    return 8'h4F;
            4'd7:    return 8'h4E;
            4'd8:    return 8'h3D;
            default: return 8'h00;
        endcase
    endfunction

    function automatic byte_t char_voltage(input logic [3:0] idx);
        case (idx)
            4'd0:    return 8'h2B;
            4'd1:    return 8'h56;
            4'd2:    return 8'h3D;
            default: return 8'h00;
        endcase
    endfunction

    function automatic byte_t char_ok(input logic [3:0] idx);
        case (idx)
            4'd0:    return 8'h4F;
            4'd1:    return 8'h4B;
            default: return 8'h00;
        endcase
    endfunction

    function automatic byte_t char_ph(input logic [3:0] idx);
        case (idx)
            4'd0:    return 8'h2B;
            4'd1:    return 8'h50;
            4'd2:    return 8'h48;
            4'd3:    return 8'h3D;
            default: return 8'h00;
        endcase
    endfunction

    // A set bit means the byte at this position keeps that prefix alive.
    function automatic logic [3:0] prefix_hits(input logic [3:0] idx, input byte_t b);
        logic [3:0] hits;
        hits[KIND_VERSION] = (idx >= LEN_VERSION) || (b == char_version(idx));
        hits[KIND_VOLTAGE] = (idx >= LEN_VOLTAGE) || (b == char_voltage(idx));
        hits[KIND_OK]      = (idx >= LEN_OK)      || (b == char_ok(idx));
        hits[KIND_PH]      = (idx >= LEN_PH)      || (b == char_ph(idx));
        return hits;
    endfunction

endpackage

FILE: sv/slrp_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module slrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/sensor_line_response_parser.sv
// ----------------------------------------------------------------------------
// Sensor line response parser
// Buffers received serial bytes and decodes CR LF terminated response lines.
// ----------------------------------------------------------------------------
// A byte that does not end a line is taken and the block stays ready for the
// next byte. A CR LF line end of at least three stored bytes starts a parse
// that reads the line buffer one entry per cycle through its single read
// port; the digit walk of a ph line makes its parse the longest. A decoded
// line gives one word on the output; the block takes no byte while a parse
// runs or while a finished word waits for a free output register.
module sensor_line_response_parser #(
    parameter int LINE_BUFFER_DEPTH = slrp_pkg::LINE_BUFFER_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  slrp_pkg::byte_t  rx_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output slrp_pkg::kind_t  line_kind,
    output slrp_pkg::value_t value
);

    import slrp_pkg::*;

    localparam int AW = $clog2(LINE_BUFFER_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(LINE_BUFFER_DEPTH - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MATCH = 3'd1;
    localparam logic [2:0] S_DIGIT = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] digit_pos(input logic is_ver, input logic [1:0] step);
        logic [3:0] p;
        case (step)
            2'd0:    p = is_ver ? 4'd9  : 4'd3;
            2'd1:    p = is_ver ? 4'd11 : 4'd5;
            default: p = is_ver ? 4'd11 : 4'd6;
        endcase
        return AW'(p);
    endfunction

    logic [2:0]                   state_reg, state_next;
    logic [AW-1:0]                fill_reg, fill_next;
    byte_t                        prev_reg, prev_next;
    logic [LINE_BUFFER_DEPTH-1:0] valid_reg, valid_next;
    logic [AW-1:0]                pos_reg, pos_next;
    logic                         lat_vld_reg, lat_vld_next;
    logic [AW-1:0]                lat_pos_reg, lat_pos_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic [3:0]                   match_reg, match_next;
    kind_t                        kind_reg, kind_next;
    value_t                       acc_reg, acc_next;
    logic [1:0]                   dstep_reg, dstep_next;
    logic [1:0]                   pstep_reg, pstep_next;
    logic [AW-1:0]                wstep_reg, wstep_next;
    byte_t                        wprev_reg, wprev_next;
    logic                         out_valid_reg, out_valid_next;
    kind_t                        line_kind_reg, line_kind_next;
    value_t                       value_reg, value_next;

    logic       ram_we;
    byte_t      ram_rdata;
    byte_t      rd_byte;
    logic       line_end;
    logic [3:0] match_hit;
    value_t     mac_digit;
    value_t     mac_out;

    slrp_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BUFFER_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (fill_reg),
        .wr_data (rx_byte),
        .rd_addr (pos_reg),
        .rd_data (ram_rdata)
    );

    assign rd_byte   = rd_valid_reg ? ram_rdata : 8'h00;
    assign line_end  = (prev_reg == BYTE_CR) && (rx_byte == BYTE_LF);
    assign match_hit = match_reg & prefix_hits(lat_pos_reg[3:0], rd_byte);
    assign mac_digit = ((state_reg == S_DIGIT) && (kind_reg == KIND_VERSION) &&
                        (pstep_reg == 2'd2)) ? '0 : ({8'h00, rd_byte} - {8'h00, DIGIT_ZERO});
    assign mac_out   = {acc_reg[12:0], 3'b000} + {acc_reg[14:0], 1'b0} + mac_digit;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        prev_next      = prev_reg;
        valid_next     = valid_reg;
        pos_next       = pos_reg;
        lat_vld_next   = lat_vld_reg;
        lat_pos_next   = lat_pos_reg;
        rd_valid_next  = valid_reg[pos_reg];
        match_next     = match_reg;
        kind_next      = kind_reg;
        acc_next       = acc_reg;
        dstep_next     = dstep_reg;
        pstep_next     = pstep_reg;
        wstep_next     = wstep_reg;
        wprev_next     = wprev_reg;
        out_valid_next = out_valid_reg;
        line_kind_next = line_kind_reg;
        value_next     = value_reg;
        ram_we         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ram_we               = 1'b1;
                    valid_next[fill_reg] = 1'b1;
                    if (line_end)
                    begin
                        if (fill_reg != LAST_IDX)
                        begin
                            valid_next[fill_reg + AW'(1)] = 1'b0;
                        end
                        fill_next = '0;
                        prev_next = 8'h00;
                        if (fill_reg >= AW'(3))
                        begin
                            state_next   = S_MATCH;
                            pos_next     = '0;
                            lat_vld_next = 1'b0;
                            match_next   = 4'b1111;
                        end
                    end
                    else
                    begin
                        fill_next = wrap_inc(fill_reg);
                        prev_next = rx_byte;
                    end
                end
            end
            S_MATCH:
            begin
                pos_next     = wrap_inc(pos_reg);
                lat_vld_next = 1'b1;
                lat_pos_next = pos_reg;
                if (lat_vld_reg)
                begin
                    match_next = match_hit;
                    if (lat_pos_reg == AW'(8))
                    begin
                        lat_vld_next = 1'b0;
                        acc_next     = '0;
                        dstep_next   = 2'd1;
                        pstep_next   = 2'd0;
                        if (match_hit[KIND_VERSION])
                        begin
                            state_next = S_DIGIT;
                            kind_next  = KIND_VERSION;
                            pos_next   = digit_pos(1'b1, 2'd0);
                        end
                        else if (match_hit[KIND_VOLTAGE])
                        begin
                            state_next = S_DIGIT;
                            kind_next  = KIND_VOLTAGE;
                            pos_next   = digit_pos(1'b0, 2'd0);
                        end
                        else if (match_hit[KIND_OK])
                        begin
                            state_next = S_EMIT;
                            kind_next  = KIND_OK;
                        end
                        else if (match_hit[KIND_PH])
                        begin
                            state_next = S_WALK;
                            kind_next  = KIND_PH;
                            pos_next   = AW'(4);
                            wstep_next = '0;
                            wprev_next = BYTE_EQUAL;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_DIGIT:
            begin
                pos_next     = digit_pos(kind_reg == KIND_VERSION, dstep_reg);
                dstep_next   = dstep_reg + 2'd1;
                lat_vld_next = 1'b1;
                if (lat_vld_reg)
                begin
                    acc_next   = mac_out;
                    pstep_next = pstep_reg + 2'd1;
                    if (pstep_reg == 2'd2)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_WALK:
            begin
                pos_next     = wrap_inc(pos_reg);
                lat_vld_next = 1'b1;
                if (lat_vld_reg)
                begin
                    if ((wprev_reg == BYTE_CR) || (rd_byte == BYTE_LF))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        if ((rd_byte != BYTE_DOT) && (rd_byte != BYTE_CR))
                        begin
                            acc_next = mac_out;
                        end
                        wprev_next = rd_byte;
                        wstep_next = wstep_reg + AW'(1);
                        if (wstep_reg == LAST_IDX)
                        begin
                            state_next = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    line_kind_next = kind_reg;
                    value_next     = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            prev_reg      <= 8'h00;
            valid_reg     <= '0;
            lat_vld_reg   <= 1'b0;
            dstep_reg     <= 2'd0;
            pstep_reg     <= 2'd0;
            wstep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            prev_reg      <= prev_next;
            valid_reg     <= valid_next;
            lat_vld_reg   <= lat_vld_next;
            dstep_reg     <= dstep_next;
            pstep_reg     <= pstep_next;
            wstep_reg     <= wstep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        lat_pos_reg   <= lat_pos_next;
        rd_valid_reg  <= rd_valid_next;
        match_reg     <= match_next;
        kind_reg      <= kind_next;
        acc_reg       <= acc_next;
        wprev_reg     <= wprev_next;
        line_kind_reg <= line_kind_next;
        value_reg     <= value_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign line_kind = line_kind_reg;
    assign value     = value_reg;

endmodule

FILE: sv/slrp_checker.sv
// ----------------------------------------------------------------------------
// Sensor line response parser checker
// Port-level assertions on the parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
module slrp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input slrp_pkg::byte_t  rx_byte,
    input logic             out_valid,
    input logic             out_ready,
    input slrp_pkg::kind_t  line_kind,
    input slrp_pkg::value_t value
);

    import slrp_pkg::*;

    // A stalled output word keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(line_kind) && $stable(value))
        else $error("output word changed while stalled");

    // An OK acknowledgement carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (line_kind == KIND_OK) |-> (value == 16'h0000))
        else $error("OK word with nonzero value");

    // A byte other than LF never ends a line, so the block stays ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (rx_byte != BYTE_LF) |=> in_ready)
        else $error("not ready after a plain byte");

    // A new output word only appears after a parse, while no byte is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("output word appeared while the input was open");

endmodule

bind sensor_line_response_parser slrp_checker u_slrp_checker (.*);
